// ===== rtl/core/bns_pkg.sv =====
// shared types and constants for the backend node selector
package bns_pkg;

  localparam int unsigned MaxNodes = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CntW     = 5;
  localparam int unsigned KeyW     = 48;
  localparam int unsigned WgtW     = 16;
  localparam int unsigned ConnW    = 16;
  localparam int unsigned RndW     = 32;
  localparam int unsigned TotW     = 20;

  localparam logic [2:0] ModeSelect   = 3'd0;
  localparam logic [2:0] ModeConnUp   = 3'd1;
  localparam logic [2:0] ModeConnDown = 3'd2;
  localparam logic [2:0] ModeHealth   = 3'd3;
  localparam logic [2:0] ModeLoad     = 3'd4;

  localparam logic [1:0] StratRr     = 2'd0;
  localparam logic [1:0] StratWeight = 2'd1;
  localparam logic [1:0] StratLeast  = 2'd2;
  localparam logic [1:0] StratRand   = 2'd3;

  localparam logic RegStrategy  = 1'b0;
  localparam logic RegNodeCount = 1'b1;

  // command passed from front to back
  typedef struct packed {
    logic [2:0]       mode;
    logic [KeyW-1:0]  key;
    logic [IdxW-1:0]  idx;
    logic [WgtW-1:0]  weight;
    logic             health;
    logic [ConnW-1:0] conns;
    logic [RndW-1:0]  rnd;
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

endpackage

// ===== rtl/core/bns_front.sv =====
// input stage: drops unknown modes and queues commands for the back end
module bns_front import bns_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  cmd_t       cmd_i,
  output logic       cmd_valid_o,
  input  logic       cmd_take_i,
  output cmd_t       cmd_o
);

  localparam int unsigned Depth = 2;

  cmd_t       mem_q [Depth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep, wr, rd;

  // classify: modes above load produce nothing
  assign keep   = cmd_i.mode <= ModeLoad;
  assign full_o = cnt_q == 2'(Depth);
  assign wr     = push_i && !full_o && keep;
  assign rd     = cmd_take_i && cmd_valid_o;

  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = mem_q[rp_q];

  // pointer and fill updates
  always_comb begin
    wp_d  = wr ? ~wp_q : wp_q;
    rp_d  = rd ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(Depth))
    else $error("front queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !wr)
    else $error("write into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !rd)
    else $error("read from empty queue");

endmodule

// ===== rtl/core/bns_divider.sv =====
// iterative remainder unit, one quotient bit per cycle
module bns_divider import bns_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RndW-1:0] num_i,
  input  logic [TotW-1:0] den_i,
  output logic            done_o,
  output logic [TotW-1:0] rem_o
);

  logic [RndW-1:0] num_q, num_d;
  logic [TotW:0]   rem_q, rem_d;
  logic [TotW-1:0] den_q, den_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [TotW:0]   sh;

  assign sh     = {rem_q[TotW-1:0], num_q[RndW-1]};
  assign rem_o  = rem_q[TotW-1:0];
  assign done_o = busy_q && cnt_q == 6'd0;

  // restoring step
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'(RndW);
      busy_d = 1'b1;
    end else if (busy_q && cnt_q != 6'd0) begin
      num_d = {num_q[RndW-2:0], 1'b0};
      rem_d = (sh >= {1'b0, den_q}) ? sh - {1'b0, den_q} : sh;
      cnt_d = cnt_q - 6'd1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

// ===== rtl/core/bns_back.sv =====
// execution engine: table, entry walks, result register
module bns_back import bns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_take_o,
  input  cmd_t             cmd_i,
  input  logic [1:0]       strategy_i,
  input  logic [CntW-1:0]  node_count_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic             found_o,
  output logic [IdxW-1:0]  node_index_o,
  output logic [KeyW-1:0]  node_key_o,
  output logic [WgtW-1:0]  node_weight_o,
  output logic             node_healthy_o,
  output logic [ConnW-1:0] node_connections_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StPick  = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [KeyW-1:0]  key_mem  [MaxNodes];
  logic [WgtW-1:0]  wgt_mem  [MaxNodes];
  logic             hlth_mem [MaxNodes];
  logic [ConnW-1:0] conn_mem [MaxNodes];

  logic [2:0]      st_q;
  cmd_t            cmd_q;
  logic [CntW-1:0] n_q, i_q;
  logic [CntW-1:0] hcnt_q;
  logic [TotW-1:0] tot_q, run_q, tgt_q;
  logic [ConnW-1:0] least_q;
  logic            have_q, hit_q, rr_q;
  logic [IdxW-1:0] pick_q;
  logic [RndW-1:0] rot_q;
  logic            res_full_q;
  logic            res_found_q;
  logic [IdxW-1:0] res_idx_q;
  logic [KeyW-1:0] res_key_q;
  logic [WgtW-1:0] res_wgt_q;
  logic            res_h_q;
  logic [ConnW-1:0] res_conn_q;

  logic            div_start, div_done;
  logic [RndW-1:0] div_num;
  logic [TotW-1:0] div_den, div_rem;
  logic [IdxW-1:0] ii;
  logic            hh;
  logic [TotW-1:0] run_nx;

  assign ii     = i_q[IdxW-1:0];
  assign hh     = hlth_mem[ii];
  assign run_nx = run_q + TotW'(wgt_mem[ii]);
  assign cmd_take_o = st_q == StIdle && cmd_valid_i;

  assign div_start = st_q == StScan && i_q == n_q && cmd_q.mode == ModeSelect
                     && hcnt_q != '0 && strategy_i != StratLeast
                     && !(strategy_i == StratWeight && tot_q == '0);
  assign div_num   = strategy_i == StratRr ? rot_q : cmd_q.rnd;
  assign div_den   = strategy_i == StratWeight ? tot_q : TotW'(hcnt_q);

  bns_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // sequencer: scan pass counts and matches, pick pass walks to target
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      rot_q      <= '0;
      res_full_q <= 1'b0;
    end else begin
      if (pop_i && res_full_q) begin
        res_full_q <= 1'b0;
      end
      case (st_q)
        StIdle: begin
          if (cmd_take_o) begin
            st_q <= (cmd_i.mode == ModeLoad) ? StIdle : StScan;
          end
        end
        StScan: begin
          if (i_q == n_q || (cmd_q.mode != ModeSelect && hit_q)) begin
            if (cmd_q.mode != ModeSelect) begin
              st_q <= StIdle;
            end else if (n_q == '0 || hcnt_q == '0 || strategy_i == StratLeast
                         || (strategy_i == StratWeight && tot_q == '0)) begin
              st_q <= StRead;
            end else begin
              st_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (div_done) begin
            st_q <= StPick;
            if (rr_q) begin
              rot_q <= rot_q + 32'd1;
            end
          end
        end
        StPick: begin
          if (hit_q) begin
            st_q <= StRead;
          end
        end
        StRead: begin
          if (!res_full_q) begin
            st_q <= StOut;
          end
        end
        StOut: begin
          if (!res_full_q) begin
            res_full_q <= 1'b1;
            st_q       <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // datapath and table
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        cmd_q   <= cmd_i;
        n_q     <= (node_count_i > CntW'(MaxNodes)) ? CntW'(MaxNodes) : node_count_i;
        i_q     <= '0;
        hcnt_q  <= '0;
        tot_q   <= '0;
        have_q  <= 1'b0;
        hit_q   <= 1'b0;
        pick_q  <= '0;
        rr_q    <= strategy_i == StratRr;
        if (cmd_take_o && cmd_i.mode == ModeLoad) begin
          key_mem[cmd_i.idx]  <= cmd_i.key;
          wgt_mem[cmd_i.idx]  <= cmd_i.weight;
          hlth_mem[cmd_i.idx] <= cmd_i.health;
          conn_mem[cmd_i.idx] <= cmd_i.conns;
        end
      end
      StScan: begin
        if (i_q != n_q && !hit_q) begin
          i_q <= i_q + 1'b1;
          if (cmd_q.mode == ModeSelect) begin
            if (hh) begin
              hcnt_q <= hcnt_q + 1'b1;
              tot_q  <= tot_q + TotW'(wgt_mem[ii]);
              if (!have_q || conn_mem[ii] < least_q) begin
                least_q <= conn_mem[ii];
                pick_q  <= ii;
                have_q  <= 1'b1;
              end
            end
          end else if (key_mem[ii] == cmd_q.key) begin
            hit_q <= 1'b1;
            case (cmd_q.mode)
              ModeConnUp:   if (conn_mem[ii] != '1) conn_mem[ii] <= conn_mem[ii] + 1'b1;
              ModeConnDown: if (conn_mem[ii] != '0) conn_mem[ii] <= conn_mem[ii] - 1'b1;
              ModeHealth:   hlth_mem[ii] <= cmd_q.health;
              default: ;
            endcase
          end
        end
        if (i_q == n_q && (hcnt_q == '0 || strategy_i == StratWeight)) begin
          pick_q <= '0;
        end
      end
      StDiv: begin
        i_q   <= '0;
        run_q <= '0;
        tgt_q <= div_rem;
        hit_q <= 1'b0;
      end
      StPick: begin
        if (!hit_q) begin
          i_q <= i_q + 1'b1;
          if (hh) begin
            if (strategy_i == StratWeight) begin
              run_q <= run_nx;
              if (tgt_q < run_nx) begin
                pick_q <= ii;
                hit_q  <= 1'b1;
              end
            end else begin
              run_q <= run_q + 1'b1;
              if (run_q == tgt_q) begin
                pick_q <= ii;
                hit_q  <= 1'b1;
              end
            end
          end
        end
      end
      StRead: begin
        if (!res_full_q) begin
          res_found_q <= n_q != '0;
          res_idx_q   <= n_q != '0 ? pick_q : '0;
          res_key_q   <= n_q != '0 ? key_mem[pick_q] : '0;
          res_wgt_q   <= n_q != '0 ? wgt_mem[pick_q] : '0;
          res_h_q     <= n_q != '0 ? hlth_mem[pick_q] : 1'b0;
          res_conn_q  <= n_q != '0 ? conn_mem[pick_q] : '0;
        end
      end
      default: ;
    endcase
  end

  assign empty_o            = !res_full_q;
  assign found_o            = res_found_q;
  assign node_index_o       = res_idx_q;
  assign node_key_o         = res_key_q;
  assign node_weight_o      = res_wgt_q;
  assign node_healthy_o     = res_h_q;
  assign node_connections_o = res_conn_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut && !res_full_q) |=> res_full_q)
    else $error("result not registered");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> st_q == StIdle)
    else $error("command taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StPick) |-> i_q <= n_q)
    else $error("pick walk overran table");

endmodule

// ===== rtl/core/backend_node_selector.sv =====
// top level: configuration registers, front queue and back-end engine
//
// backend node selector
// input channel: push / full, one command per transaction (mode, key,
//   entry fields, random value). modes above load entry are dropped.
// result channel: empty / pop, one transaction per select command,
//   result held on the node ports while empty is low.
// configuration: apb port, strategy at 0x0, node_count at 0x4; write only
//   while idle. pready is always high.
// steps: load writes its entry from idle; connection/health use the
//   one-entry-per-cycle key walk; select runs a table scan, a shift-subtract
//   remainder and a pick walk (skipped for least connections or when no
//   healthy entry or weight exists), a table read and the result register.
// a two-entry command queue lets the front accept while the back works.
// reset clears strategy, node count, rotation counter and both queues;
//   table entries hold garbage until loaded.
// a stalled result holds only the next select, at its table read; other
//   commands keep executing until then, after that the input queue fills.
module backend_node_selector import bns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       mode_i,
  input  logic [KeyW-1:0]  endpoint_key_i,
  input  logic [IdxW-1:0]  entry_index_i,
  input  logic [WgtW-1:0]  entry_weight_i,
  input  logic             health_flag_i,
  input  logic [ConnW-1:0] entry_connections_i,
  input  logic [RndW-1:0]  random_value_i,
  output logic             empty,
  input  logic             pop,
  output logic             found_o,
  output logic [IdxW-1:0]  node_index_o,
  output logic [KeyW-1:0]  node_key_o,
  output logic [WgtW-1:0]  node_weight_o,
  output logic             node_healthy_o,
  output logic [ConnW-1:0] node_connections_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0]      strategy_q;
  logic [CntW-1:0] node_count_q;
  logic            cwr;
  cmd_t            cmd_in, cmd_out;
  logic            cmd_valid, cmd_take;

  // configuration registers
  assign pready = 1'b1;
  assign cwr    = psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == RegStrategy
                  ? 1'b1 : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q   <= '0;
      node_count_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegStrategy) begin
        strategy_q <= pwdata[1:0];
      end else begin
        node_count_q <= pwdata[CntW-1:0];
      end
    end
  end

  assign prdata = paddr[2] == RegStrategy ? {30'd0, strategy_q}
                                          : {27'd0, node_count_q};

  assign cmd_in = '{mode: mode_i, key: endpoint_key_i, idx: entry_index_i,
                    weight: entry_weight_i, health: health_flag_i,
                    conns: entry_connections_i, rnd: random_value_i};

  bns_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .cmd_i      (cmd_in),
    .cmd_valid_o(cmd_valid),
    .cmd_take_i (cmd_take),
    .cmd_o      (cmd_out)
  );

  bns_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_take_o        (cmd_take),
    .cmd_i             (cmd_out),
    .strategy_i        (strategy_q),
    .node_count_i      (node_count_q),
    .empty_o           (empty),
    .pop_i             (pop),
    .found_o           (found_o),
    .node_index_o      (node_index_o),
    .node_key_o        (node_key_o),
    .node_weight_o     (node_weight_o),
    .node_healthy_o    (node_healthy_o),
    .node_connections_o(node_connections_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cwr && pready) |=> strategy_q == $past(pwdata[1:0]))
    else $error("strategy write lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni) node_count_q <= 5'd31)
    else $error("node count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped while stalled");

endmodule
